>>> src/slt_pkg.sv
package slt_pkg;

    // Default storage depth, one entry per sensor.
    localparam int SENSOR_COUNT_DEFAULT = 16;

    // Field widths.
    localparam int IDX_W   = 4;
    localparam int LEVEL_W = 8;

    // Level and countdown constants.
    localparam logic [LEVEL_W-1:0] LOW_RESET  = 8'd255;
    localparam logic [LEVEL_W-1:0] HIGH_RESET = 8'd50;
    localparam logic [LEVEL_W:0]   LIFT       = 9'd50;
    localparam logic [LEVEL_W:0]   LEVEL_MAX  = 9'd255;
    localparam logic [LEVEL_W:0]   ACT_MARGIN = 9'd20;

    // Configuration registers.
    localparam logic CFG_HOLD_TIME  = 1'b0;
    localparam logic CFG_BRIGHTNESS = 1'b1;

    localparam logic [LEVEL_W-1:0] HOLD_RESET   = 8'd100;
    localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd200;

    // hold_time / 6 as (hold_time * 171) >> 10, exact for all 8-bit values.
    localparam logic [LEVEL_W-1:0] RECIP_SIX   = 8'd171;
    localparam int                 RECIP_SHIFT = 10;
    localparam logic [LEVEL_W-1:0] BAND_RESET  = 8'd16;

    // Input kinds.
    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    // Control into the state store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_levels;
    } slt_store_ctl_t;

    // Updated sensor state and its color.
    typedef struct packed {
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] countdown;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } slt_result_t;

endpackage

>>> src/slt_store.sv
module slt_store #(
    parameter int SENSOR_COUNT = slt_pkg::SENSOR_COUNT_DEFAULT,
    parameter int AW           = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slt_pkg::slt_store_ctl_t      ctl,
    input  logic [AW-1:0]                rd_addr,
    input  logic [AW-1:0]                wr_addr,
    input  logic [slt_pkg::LEVEL_W-1:0]  wr_low,
    input  logic [slt_pkg::LEVEL_W-1:0]  wr_high,
    input  logic [slt_pkg::LEVEL_W-1:0]  wr_count,
    output logic [slt_pkg::LEVEL_W-1:0]  rd_low,
    output logic [slt_pkg::LEVEL_W-1:0]  rd_high,
    output logic [slt_pkg::LEVEL_W-1:0]  rd_count
);
    import slt_pkg::*;

    // Levels share one word: high level in the upper byte.
    logic [2*LEVEL_W-1:0] lvl_mem [SENSOR_COUNT];
    logic [LEVEL_W-1:0]   cnt_mem [SENSOR_COUNT];

    // An entry whose valid bit is low reads as its reset value.
    logic [SENSOR_COUNT-1:0] lvl_valid_reg;
    logic [SENSOR_COUNT-1:0] cnt_valid_reg;

    logic [2*LEVEL_W-1:0] lvl_rd_reg;
    logic [LEVEL_W-1:0]   cnt_rd_reg;
    logic                 lvl_ok_reg;
    logic                 cnt_ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            lvl_mem[wr_addr] <= {wr_high, wr_low};
            cnt_mem[wr_addr] <= wr_count;
        end
        if (ctl.rd_en)
        begin
            lvl_rd_reg <= lvl_mem[rd_addr];
            cnt_rd_reg <= cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_valid_reg <= '0;
            cnt_valid_reg <= '0;
            lvl_ok_reg    <= 1'b0;
            cnt_ok_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.clr_levels)
            begin
                lvl_valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                lvl_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.wr_en)
            begin
                cnt_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                lvl_ok_reg <= lvl_valid_reg[rd_addr];
                cnt_ok_reg <= cnt_valid_reg[rd_addr];
            end
        end
    end

    assign rd_low   = lvl_ok_reg ? lvl_rd_reg[LEVEL_W-1:0]         : LOW_RESET;
    assign rd_high  = lvl_ok_reg ? lvl_rd_reg[2*LEVEL_W-1:LEVEL_W] : HIGH_RESET;
    assign rd_count = cnt_ok_reg ? cnt_rd_reg                      : '0;

endmodule

>>> src/slt_update.sv
module slt_update (
    input  logic [slt_pkg::LEVEL_W-1:0] low,
    input  logic [slt_pkg::LEVEL_W-1:0] high,
    input  logic [slt_pkg::LEVEL_W-1:0] count,
    input  logic [slt_pkg::LEVEL_W-1:0] reading,
    input  logic [slt_pkg::LEVEL_W-1:0] hold_time,
    input  logic [slt_pkg::LEVEL_W-1:0] band,
    input  logic [slt_pkg::LEVEL_W-1:0] brightness,
    output slt_pkg::slt_result_t        result
);
    import slt_pkg::*;

    logic [LEVEL_W-1:0] lo_new;
    logic [LEVEL_W-1:0] hi_lift;
    logic [LEVEL_W-1:0] hi_new;
    logic [LEVEL_W-1:0] cnt_new;
    logic [LEVEL_W:0]   rd_lift;
    logic [LEVEL_W:0]   lo_margin;
    logic [LEVEL_W-1:0] half;
    logic [LEVEL_W+2:0] band1;
    logic [LEVEL_W+2:0] band2;
    logic [LEVEL_W+2:0] band3;
    logic [LEVEL_W+2:0] band4;
    logic [LEVEL_W+2:0] band5;
    logic [LEVEL_W+2:0] c_ext;

    always_comb
    begin
        rd_lift = {1'b0, reading} + LIFT;
        // The high level survives a new low only while it sits above low + 50.
        if ({1'b0, high} > rd_lift)
        begin
            hi_lift = high;
        end
        else if (rd_lift > LEVEL_MAX)
        begin
            hi_lift = LEVEL_MAX[LEVEL_W-1:0];
        end
        else
        begin
            hi_lift = rd_lift[LEVEL_W-1:0];
        end

        lo_new = low;
        hi_new = high;
        if (reading < low)
        begin
            lo_new = reading;
            hi_new = hi_lift;
        end
        if (reading > hi_new)
        begin
            hi_new = reading;
        end

        lo_margin = {1'b0, lo_new} + ACT_MARGIN;
        if ({1'b0, reading} > lo_margin)
        begin
            cnt_new = hold_time;
        end
        else if (count != '0)
        begin
            cnt_new = count - 1'b1;
        end
        else
        begin
            cnt_new = '0;
        end
    end

    always_comb
    begin
        half  = brightness >> 1;
        c_ext = {3'b000, cnt_new};
        band1 = {3'b000, band};
        band2 = {2'b00, band, 1'b0};
        band3 = band2 + band1;
        band4 = {1'b0, band, 2'b00};
        band5 = band4 + band1;

        result.min_level = lo_new;
        result.max_level = hi_new;
        result.countdown = cnt_new;
        result.red       = '0;
        result.green     = '0;
        result.blue      = '0;
        if (cnt_new == '0)
        begin
            // Inactive sensor shows black.
        end
        else if (c_ext < band1)
        begin
            result.green = brightness;
        end
        else if (c_ext < band2)
        begin
            result.red   = half;
            result.green = half;
        end
        else if (c_ext < band3)
        begin
            result.red = brightness;
        end
        else if (c_ext < band4)
        begin
            result.red  = half;
            result.blue = half;
        end
        else if (c_ext < band5)
        begin
            result.blue = brightness;
        end
        else
        begin
            result.green = half;
            result.blue  = half;
        end
    end

endmodule

>>> src/sensor_level_tracker_activity_color.sv
// A reading first loads its sensor entry into the store's read registers; the entry is then
// updated, written back and captured in the output register behind m_tvalid. No new
// transaction is taken during that update or while a waiting result is not being taken.
// A clear transaction returns no result; out-of-range readings are dropped.
// Reset is asynchronous: levels read as 255/50 and countdowns as zero through per-entry
// valid bits, so no clearing pass runs; hold_time resets to 100 and brightness to 200.
module sensor_level_tracker_activity_color #(
    parameter int SENSOR_COUNT = slt_pkg::SENSOR_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // sensor_index[3:0], reading[11:4], zero pad [15:12]
    input  logic        s_tuser,    // kind: 0 = reading, 1 = clear level history
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // sensor_id[3:0], min_level[11:4], max_level[19:12],
                                    // countdown[27:20], red[35:28], green[43:36],
                                    // blue[51:44], zero pad [55:52]
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import slt_pkg::*;

    localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    // Configuration registers. The color band width hold_time / 6 is
    // computed once when hold_time is written.
    logic [LEVEL_W-1:0] hold_reg;
    logic [LEVEL_W-1:0] bright_reg;
    logic [LEVEL_W-1:0] band_reg;
    logic [2*LEVEL_W-1:0] band_prod;

    assign band_prod = {8'd0, cfg_data} * {8'd0, RECIP_SIX};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= HOLD_RESET;
            bright_reg <= BRIGHT_RESET;
            band_reg   <= BAND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD_TIME:
                begin
                    hold_reg <= cfg_data;
                    // The quotient is at most 42, so six bits carry it.
                    band_reg <= {2'b00, band_prod[2*LEVEL_W-1:RECIP_SHIFT]};
                end
                CFG_BRIGHTNESS:
                begin
                    bright_reg <= cfg_data;
                end
                default:
                begin
                    hold_reg <= hold_reg;
                end
            endcase
        end
    end

    // Input decode.
    logic [IDX_W-1:0]   in_idx;
    logic [LEVEL_W-1:0] in_reading;
    logic [8:0]         idx_ext;
    logic               in_range;
    logic               s_accept;
    logic               start_rmw;

    assign in_idx     = s_tdata[IDX_W-1:0];
    assign in_reading = s_tdata[IDX_W+LEVEL_W-1:IDX_W];
    assign idx_ext    = {5'd0, in_idx};
    assign in_range   = idx_ext < 9'(SENSOR_COUNT);
    assign s_accept   = s_tvalid && s_tready;
    assign start_rmw  = s_accept && (s_tuser == KIND_READING) && in_range;

    // busy_reg marks the cycle in which the store's read data is updated and
    // written back. No new transaction is taken then, so a following reading
    // of the same sensor always sees the written entry.
    logic               busy_reg;
    logic               busy_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEVEL_W-1:0] reading_reg;

    assign busy_next = start_rmw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_rmw)
        begin
            idx_reg     <= in_idx;
            reading_reg <= in_reading;
        end
    end

    // Output register; a transaction is taken only when the result slot will
    // be free by the time its update finishes.
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [55:0] m_tdata_reg;

    assign s_tready = !busy_reg && (!m_tvalid_reg || m_tready);

    // State store.
    slt_store_ctl_t     store_ctl;
    logic [LEVEL_W-1:0] rd_low;
    logic [LEVEL_W-1:0] rd_high;
    logic [LEVEL_W-1:0] rd_count;
    slt_result_t        upd;

    assign store_ctl.rd_en      = start_rmw;
    assign store_ctl.wr_en      = busy_reg;
    assign store_ctl.clr_levels = s_accept && (s_tuser == KIND_CLEAR);

    slt_store #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .AW           (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (store_ctl),
        .rd_addr  (AW'(idx_ext)),
        .wr_addr  (AW'({5'd0, idx_reg})),
        .wr_low   (upd.min_level),
        .wr_high  (upd.max_level),
        .wr_count (upd.countdown),
        .rd_low   (rd_low),
        .rd_high  (rd_high),
        .rd_count (rd_count)
    );

    slt_update u_update (
        .low        (rd_low),
        .high       (rd_high),
        .count      (rd_count),
        .reading    (reading_reg),
        .hold_time  (hold_reg),
        .band       (band_reg),
        .brightness (bright_reg),
        .result     (upd)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (busy_reg)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            m_tdata_reg <= {4'd0, upd.blue, upd.green, upd.red, upd.countdown,
                            upd.max_level, upd.min_level, idx_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The update cycle never accepts a new transaction.
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_tready)
        else $error("input accepted during store update");

    // A started update always raises busy_reg and then produces a result on m_tvalid.
    a_rmw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        start_rmw |=> busy_reg ##1 m_tvalid)
        else $error("reading did not produce a result");

    // An update never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !m_tvalid_reg || $past(m_tready))
        else $error("pending result overwritten");

    // A clear or a dropped reading starts no store update.
    a_clear_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser == KIND_CLEAR || !in_range)) |=> !busy_reg)
        else $error("clear or dropped reading started an update");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    import slt_pkg::*;

    localparam int SENSORS          = SENSOR_COUNT_DEFAULT;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 210;
    localparam int BACKUP_CYCLES    = 400;

    // One result transaction, unpacked into its fields.
    typedef struct {
        logic [IDX_W-1:0]   sensor_id;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] countdown;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } level_report_t;

    // One row of the directed table. When known is set, want holds the result
    // typed in by hand; otherwise the tracker model supplies it.
    typedef struct {
        logic               kind;
        logic [IDX_W-1:0]   sensor;
        logic [LEVEL_W-1:0] reading;
        bit                 known;
        level_report_t      want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // sensor_index[3:0], reading[11:4], zero pad [15:12]
    logic        s_tuser;     // kind: reading or clear
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;     // sensor_id[3:0], min_level[11:4], max_level[19:12],
                              // countdown[27:20], red[35:28], green[43:36],
                              // blue[51:44], zero pad [55:52]
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    // Tracker model state: levels and countdowns per sensor plus the two registers.
    logic [LEVEL_W-1:0] lvl_low   [SENSORS];
    logic [LEVEL_W-1:0] lvl_high  [SENSORS];
    logic [LEVEL_W-1:0] act_count [SENSORS];
    logic [LEVEL_W-1:0] hold_cfg;
    logic [LEVEL_W-1:0] bright_cfg;

    // Results still owed by the block, oldest first.
    level_report_t pending_reports [$];

    // The typed-in expectation of the transaction currently offered. These change
    // together with s_tdata, so the scoreboard sees them consistently.
    bit            item_known;
    level_report_t item_want;

    // The stimulus keeps its own copy of each sensor's low level; it always equals
    // the model's, since the low level is just the smallest reading since a clear.
    int low_guess [SENSORS];

    bit tx_quiet;
    bit rx_quiet;
    bit rx_backup_req;

    int mismatches;
    int results_checked;
    int items_sent;
    int clears_sent;
    int settings_used;

    sensor_level_tracker_activity_color uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop. The slowest correct run is far below this.
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input int sensor);
        if (got != want)
            log_mismatch($sformatf("sensor %0d %s: got %0d, expected %0d",
                                   sensor, name, got, want));
    endtask

    // Applies one input transaction to the model. Returns 1 and the expected
    // result for a reading; a clear returns nothing.
    function automatic bit track_reading(input logic kind, input logic [IDX_W-1:0] s,
                                         input logic [LEVEL_W-1:0] rd,
                                         output level_report_t rep);
        int lo;
        int hi;
        int cnt;
        int rv;
        int d;
        int half;
        int full;
        rep = '{default: '0};
        if (kind == KIND_CLEAR)
        begin
            // Levels go back to their reset values; countdowns keep running.
            for (int i = 0; i < SENSORS; i++)
            begin
                lvl_low[i]  = LOW_RESET;
                lvl_high[i] = HIGH_RESET;
            end
            return 1'b0;
        end
        if (int'(s) >= SENSORS)
            return 1'b0;

        rv  = int'(rd);
        lo  = int'(lvl_low[s]);
        hi  = int'(lvl_high[s]);
        cnt = int'(act_count[s]);

        if (rv < lo)
        begin
            lo = rv;
            // The high level survives only while it sits more than the lift above
            // the new reading; otherwise it is pulled to low + lift, clipped.
            if (!(hi >= int'(LIFT) && hi - int'(LIFT) > rv))
                hi = (lo + int'(LIFT) > int'(LEVEL_MAX)) ? int'(LEVEL_MAX) : lo + int'(LIFT);
        end
        if (rv > hi)
            hi = rv;
        if (rv > lo + int'(ACT_MARGIN))
            cnt = int'(hold_cfg);
        else if (cnt > 0)
            cnt--;

        lvl_low[s]   = LEVEL_W'(lo);
        lvl_high[s]  = LEVEL_W'(hi);
        act_count[s] = LEVEL_W'(cnt);

        // Six equal bands over the hold time; with a hold time below six every
        // nonzero count lands in the last band.
        d    = int'(hold_cfg) / 6;
        full = int'(bright_cfg);
        half = full / 2;
        rep.sensor_id = s;
        rep.min_level = LEVEL_W'(lo);
        rep.max_level = LEVEL_W'(hi);
        rep.countdown = LEVEL_W'(cnt);
        if (cnt == 0)
            rep.red = '0;
        else if (cnt < d)
            rep.green = LEVEL_W'(full);
        else if (cnt < 2 * d)
        begin
            rep.red   = LEVEL_W'(half);
            rep.green = LEVEL_W'(half);
        end
        else if (cnt < 3 * d)
            rep.red = LEVEL_W'(full);
        else if (cnt < 4 * d)
        begin
            rep.red  = LEVEL_W'(half);
            rep.blue = LEVEL_W'(half);
        end
        else if (cnt < 5 * d)
            rep.blue = LEVEL_W'(full);
        else
        begin
            rep.green = LEVEL_W'(half);
            rep.blue  = LEVEL_W'(half);
        end
        return 1'b1;
    endfunction

    // Scoreboard. On every edge the result transaction, if any, is checked first
    // against the oldest expectation; then an accepted input transaction is run
    // through the model and its result, if any, is queued.
    always @(posedge clk)
    begin : scoreboard
        level_report_t got;
        level_report_t want;
        level_report_t pred;
        bit            has_result;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.sensor_id = m_tdata[3:0];
                got.min_level = m_tdata[11:4];
                got.max_level = m_tdata[19:12];
                got.countdown = m_tdata[27:20];
                got.red       = m_tdata[35:28];
                got.green     = m_tdata[43:36];
                got.blue      = m_tdata[51:44];
                if (pending_reports.size() == 0)
                    log_mismatch($sformatf("result for sensor %0d with none expected",
                                           got.sensor_id));
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("sensor_id", got.sensor_id, want.sensor_id, want.sensor_id);
                    check_field("min_level", got.min_level, want.min_level, want.sensor_id);
                    check_field("max_level", got.max_level, want.max_level, want.sensor_id);
                    check_field("countdown", got.countdown, want.countdown, want.sensor_id);
                    check_field("red", got.red, want.red, want.sensor_id);
                    check_field("green", got.green, want.green, want.sensor_id);
                    check_field("blue", got.blue, want.blue, want.sensor_id);
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                has_result = track_reading(s_tuser, s_tdata[3:0], s_tdata[11:4], pred);
                if (has_result)
                    pending_reports.push_back(item_known ? item_want : pred);
            end
        end
    end

    // Result side. Normally tready drops about 30 percent of the time. On request it
    // holds off for a long stretch so that the block backs up and stalls its input.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_backup_req)
            begin
                hold_left     = BACKUP_CYCLES;
                rx_backup_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_quiet)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 30);
        end
    end

    // Offers one input transaction and returns at the edge where it is taken.
    // Each step assigns s_tvalid at most once: either it drops for a gap, or the
    // next transaction goes out directly at the edge that took the previous one.
    task automatic offer_item(input logic kind, input logic [IDX_W-1:0] s,
                              input logic [LEVEL_W-1:0] rd, input bit known,
                              input level_report_t want);
        int gap;
        gap = 0;
        if (!tx_quiet && $urandom_range(99) < 30)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= kind;
        s_tdata    <= {4'b0000, rd, s};
        item_known <= known;
        item_want  <= want;
        if (kind == KIND_CLEAR)
        begin
            clears_sent++;
            for (int i = 0; i < SENSORS; i++)
                low_guess[i] = int'(LOW_RESET);
        end
        else if (int'(rd) < low_guess[s])
            low_guess[s] = int'(rd);
        items_sent++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops offering, waits for every owed result, then lets a clear that may
    // still be in flight finish before anything else happens. The first edge
    // makes sure the last accepted reading has been queued by the scoreboard.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] hold, input logic [7:0] bright);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HOLD_TIME;
        cfg_data  <= hold;
        @(posedge clk);
        hold_cfg = hold;
        cfg_index <= CFG_BRIGHTNESS;
        cfg_data  <= bright;
        @(posedge clk);
        bright_cfg = bright;
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        stim_row_t     dir_rows [$];
        level_report_t blank;
        int            phase_hold   [PHASES];
        int            phase_bright [PHASES];
        int            rd;
        int            s;
        int            sel;
        int            run_left;
        int            run_sensor;
        logic          kind;

        // Every input is at a known value from time zero.
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_READING;
        cfg_we        = 1'b0;
        cfg_index     = CFG_HOLD_TIME;
        cfg_data      = '0;
        item_known    = 1'b0;
        item_want     = '{default: '0};
        blank         = '{default: '0};
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        rx_backup_req = 1'b0;
        mismatches      = 0;
        results_checked = 0;
        items_sent      = 0;
        clears_sent     = 0;
        settings_used   = 1;
        run_left        = 0;
        run_sensor      = 0;

        // Model state after reset.
        for (int i = 0; i < SENSORS; i++)
        begin
            lvl_low[i]   = LOW_RESET;
            lvl_high[i]  = HIGH_RESET;
            act_count[i] = '0;
            low_guess[i] = int'(LOW_RESET);
        end
        hold_cfg   = HOLD_RESET;
        bright_cfg = BRIGHT_RESET;

        // Directed table, run at the reset settings (hold 100, so bands of 16, and
        // brightness 200, so a half channel is 100).
        // Lowest reading on a fresh sensor: low 0, high lifted to 50, stays idle.
        dir_rows.push_back('{KIND_READING, 4'd0, 8'd0, 1'b1,
                             '{4'd0, 8'd0, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0}});
        // Highest reading on the last sensor: it raises only the high level, and
        // the activation test must not wrap at 255 + 20.
        dir_rows.push_back('{KIND_READING, 4'd15, 8'd255, 1'b1,
                             '{4'd15, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}});
        dir_rows.push_back('{KIND_READING, 4'd1, 8'd200, 1'b1,
                             '{4'd1, 8'd200, 8'd250, 8'd0, 8'd0, 8'd0, 8'd0}});
        // 21 above the low level activates: full count, top band.
        dir_rows.push_back('{KIND_READING, 4'd1, 8'd221, 1'b1,
                             '{4'd1, 8'd200, 8'd250, 8'd100, 8'd0, 8'd100, 8'd100}});
        // Exactly 20 above does not; the countdown just steps.
        dir_rows.push_back('{KIND_READING, 4'd1, 8'd220, 1'b1,
                             '{4'd1, 8'd200, 8'd250, 8'd99, 8'd0, 8'd100, 8'd100}});
        // New low near the top: the lifted high level clips at 255.
        dir_rows.push_back('{KIND_READING, 4'd2, 8'd230, 1'b1,
                             '{4'd2, 8'd230, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}});
        dir_rows.push_back('{KIND_READING, 4'd2, 8'd255, 1'b1,
                             '{4'd2, 8'd230, 8'd255, 8'd100, 8'd0, 8'd100, 8'd100}});
        // New low far below a high level: the high level is kept.
        dir_rows.push_back('{KIND_READING, 4'd15, 8'd100, 1'b1,
                             '{4'd15, 8'd100, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}});
        dir_rows.push_back('{KIND_READING, 4'd15, 8'd200, 1'b0, blank});
        dir_rows.push_back('{KIND_READING, 4'd3, 8'd5, 1'b0, blank});
        dir_rows.push_back('{KIND_READING, 4'd3, 8'd26, 1'b0, blank});
        dir_rows.push_back('{KIND_READING, 4'd3, 8'd25, 1'b0, blank});
        // A clear carries no result; its other fields do not matter.
        dir_rows.push_back('{KIND_CLEAR, 4'd7, 8'h5A, 1'b0, blank});
        // After the clear: low restarts from 255 and the countdown kept running.
        dir_rows.push_back('{KIND_READING, 4'd1, 8'd250, 1'b1,
                             '{4'd1, 8'd250, 8'd255, 8'd98, 8'd0, 8'd100, 8'd100}});
        dir_rows.push_back('{KIND_READING, 4'd0, 8'd255, 1'b0, blank});
        dir_rows.push_back('{KIND_CLEAR, 4'd15, 8'd255, 1'b0, blank});
        dir_rows.push_back('{KIND_READING, 4'd5, 8'd128, 1'b0, blank});
        dir_rows.push_back('{KIND_READING, 4'd10, 8'd170, 1'b0, blank});

        // Register settings per random phase: small hold times walk the countdown
        // through every band quickly; zero, one and 255 are the extremes.
        phase_hold   = '{12, 0, 255, 1, 6, 30, 0, 0};
        phase_bright = '{255, 0, 1, 128, 255, 77, 0, 0};
        phase_hold[6]   = $urandom_range(2, 60);
        phase_bright[6] = $urandom_range(255);
        phase_hold[7]   = $urandom_range(255);
        phase_bright[7] = $urandom_range(255);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].kind, dir_rows[i].sensor, dir_rows[i].reading,
                       dir_rows[i].known, dir_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_regs(8'(phase_hold[p]), 8'(phase_bright[p]));
            // One phase runs with both sides streaming flat out; another starts
            // with the long receiver hold-off while the sender keeps pushing.
            tx_quiet = (p == 4);
            rx_quiet = (p == 4);
            if (p == 2)
                rx_backup_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                kind = KIND_READING;
                // Now and then a run of quiet readings on one sensor, so that its
                // countdown walks down through the bands to zero.
                if (run_left == 0 && $urandom_range(99) < 8)
                begin
                    run_sensor = $urandom_range(SENSORS - 1);
                    run_left   = $urandom_range(5, 40);
                end
                if (run_left > 0)
                begin
                    s  = run_sensor;
                    rd = low_guess[s] + $urandom_range(20);
                    run_left--;
                end
                else if ($urandom_range(99) < 3)
                begin
                    kind = KIND_CLEAR;
                    s    = $urandom_range(SENSORS - 1);
                    rd   = $urandom_range(255);
                end
                else
                begin
                    s   = $urandom_range(1) ? $urandom_range(3) : $urandom_range(SENSORS - 1);
                    sel = $urandom_range(99);
                    if (sel < 30)
                        rd = low_guess[s] + $urandom_range(20);
                    else if (sel < 40)
                        rd = low_guess[s] + int'(ACT_MARGIN) + 1;
                    else if (sel < 50)
                        rd = low_guess[s] - 1;
                    else if (sel < 60)
                        rd = $urandom_range(1) ? 255 : 0;
                    else
                        rd = $urandom_range(255);
                end
                if (rd > 255)
                    rd = 255;
                if (rd < 0)
                    rd = 0;
                offer_item(kind, IDX_W'(s), LEVEL_W'(rd), 1'b0, blank);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (pending_reports.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_reports.size()));

        $display("Sent %0d input transactions (%0d clears) over %0d register settings,",
                 items_sent, clears_sent, settings_used);
        $display("checked %0d results, including a %0d-cycle result-side hold-off.",
                 results_checked, BACKUP_CYCLES);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/slt_pkg.sv
src/slt_store.sv
src/slt_update.sv
src/sensor_level_tracker_activity_color.sv
verif/tb.sv
